[design/mfcr_pkg.sv]
// Package for the mixed fraction compare and reduce core.
// Holds field widths, the stream item layouts and the default value width.
package mfcr_pkg;

  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // Input item, first field in the lowest bits
  typedef struct packed {
    logic [FIELD_W-1:0] denom_b;
    logic [FIELD_W-1:0] numer_b;
    logic [FIELD_W-1:0] whole_b;
    logic [FIELD_W-1:0] denom_a;
    logic [FIELD_W-1:0] numer_a;
    logic [FIELD_W-1:0] whole_a;
  } in_item_t;

  // Result item, first field in the lowest bits, zero padded to whole bytes
  typedef struct packed {
    logic [5:0]         pad;
    logic               zero_denominator;
    logic [FIELD_W-1:0] red_denom_b;
    logic [FIELD_W-1:0] red_numer_b;
    logic [FIELD_W-1:0] red_denom_a;
    logic [FIELD_W-1:0] red_numer_a;
    logic               a_greater;
  } out_item_t;

  localparam int unsigned IN_DATA_W  = $bits(in_item_t);
  localparam int unsigned OUT_DATA_W = $bits(out_item_t);
  localparam int unsigned OUT_ZD_BIT = 4 * FIELD_W + 1;

endpackage

[design/mfcr_mul.sv]
// Bit-serial shift-add multiplier with an initial addend: prod = mcand * mplier + addend.
// One multiplier bit per cycle. Uses mfcr_pkg.
module mfcr_mul #(
  parameter int unsigned VALUE_WIDTH = mfcr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [2*VALUE_WIDTH-1:0]   mcand_i,
  input  logic [VALUE_WIDTH-1:0]     mplier_i,
  input  logic [2*VALUE_WIDTH-1:0]   addend_i,
  output logic                       done_o,
  output logic [3*VALUE_WIDTH-1:0]   prod_o
);
  import mfcr_pkg::*;

  localparam int unsigned PROD_W = 3 * VALUE_WIDTH;
  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] mcand_q;
  logic [VALUE_WIDTH-1:0] mplier_q;
  logic [PROD_W-1:0] acc_q;
  logic [PROD_W-1:0] acc_d;
  logic              last;

  assign last  = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
  assign acc_d = acc_q + (mplier_q[0] ? mcand_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= PROD_W'(mcand_i);
      mplier_q <= mplier_i;
      acc_q    <= PROD_W'(addend_i);
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[design/mfcr_div.sv]
// Restoring divider, one quotient bit per cycle.
// Serves the Euclid modulo steps and the reducing divisions. Uses mfcr_pkg.
module mfcr_div #(
  parameter int unsigned VALUE_WIDTH = mfcr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quot_o,
  output logic [VALUE_WIDTH-1:0] rem_o
);
  import mfcr_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  logic                   busy_q;
  logic                   done_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [VALUE_WIDTH-1:0] dvs_q;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;
  logic                   last;

  assign last  = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = !diff[VALUE_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[design/mixed_fraction_compare_reduce_core.sv]
// Top level of the mixed fraction compare and reduce core: sequencer and stream ports.
// Depends on mfcr_pkg, mfcr_mul and mfcr_div.
//
// Usage: an input item on the s_axis channel carries two mixed fractions
// (whole, numerator, denominator). The block returns one result item on the
// m_axis channel: whether the first is strictly greater, both fraction parts
// reduced by their gcd, and a flag for a zero denominator (other fields zero).
// s_axis_tready_o is high only while the sequencer is idle; one item is in
// work at a time. The comparison runs four bit-serial products on the shared
// multiplier. Each fraction part with a non-zero numerator then takes (k+2)
// divisions on the shared divider, k being its number of Euclid modulo steps.
// An item with a zero denominator skips the products and goes straight to
// the result. The input is ready again once the result is loaded.
// The result sits in an output register; the next input item is accepted
// while it waits, and the sequencer holds its finished result until the
// output register frees up. Reset clears the sequencer and drops any
// pending result.
module mixed_fraction_compare_reduce_core #(
  parameter int unsigned VALUE_WIDTH = mfcr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // whole_a, numer_a, denom_a, whole_b, numer_b, denom_b (16 bits each), lowest first
  input  logic [mfcr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // a_greater (1), red_numer_a, red_denom_a, red_numer_b, red_denom_b (16 each),
  // zero_denominator (1), zero padding (6), lowest first
  output logic [mfcr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import mfcr_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_IA,
    ST_MUL_XA,
    ST_MUL_IB,
    ST_MUL_XB,
    ST_GCD_A,
    ST_DIVN_A,
    ST_DIVD_A,
    ST_GCD_B,
    ST_DIVN_B,
    ST_DIVD_B,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   start_q;

  in_item_t  in_item;
  out_item_t out_q;
  logic      m_valid_q;

  logic [W-1:0]   wa_q, na_q, da_q, wb_q, nb_q, db_q;
  logic [W-1:0]   big_q, small_q;
  logic [W-1:0]   rna_q, rda_q, rnb_q, rdb_q;
  logic [3*W-1:0] xa_q;
  logic           gt_q;
  logic           zd_q;

  logic           mul_start, mul_done;
  logic [2*W-1:0] mul_mcand, mul_addend;
  logic [W-1:0]   mul_mplier;
  logic [3*W-1:0] mul_prod;

  logic           div_start, div_done;
  logic [W-1:0]   div_dividend, div_divisor, div_quot, div_rem;

  logic           s_accept;
  logic           out_free;

  assign in_item  = in_item_t'(s_axis_tdata_i);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Operand selection for the shared units
  always_comb begin
    mul_start    = 1'b0;
    div_start    = 1'b0;
    mul_mcand    = '0;
    mul_mplier   = '0;
    mul_addend   = '0;
    div_dividend = big_q;
    div_divisor  = small_q;
    unique case (state_q)
      ST_MUL_IA: begin
        mul_start  = start_q;
        mul_mcand  = (2*W)'(wa_q);
        mul_mplier = da_q;
        mul_addend = (2*W)'(na_q);
      end
      ST_MUL_XA: begin
        mul_start  = start_q;
        mul_mcand  = mul_prod[2*W-1:0];
        mul_mplier = db_q;
      end
      ST_MUL_IB: begin
        mul_start  = start_q;
        mul_mcand  = (2*W)'(wb_q);
        mul_mplier = db_q;
        mul_addend = (2*W)'(nb_q);
      end
      ST_MUL_XB: begin
        mul_start  = start_q;
        mul_mcand  = mul_prod[2*W-1:0];
        mul_mplier = da_q;
      end
      ST_GCD_A, ST_GCD_B: begin
        div_start = start_q;
      end
      ST_DIVN_A: begin
        div_start    = start_q;
        div_dividend = na_q;
        div_divisor  = big_q;
      end
      ST_DIVD_A: begin
        div_start    = start_q;
        div_dividend = da_q;
        div_divisor  = big_q;
      end
      ST_DIVN_B: begin
        div_start    = start_q;
        div_dividend = nb_q;
        div_divisor  = big_q;
      end
      ST_DIVD_B: begin
        div_start    = start_q;
        div_dividend = db_q;
        div_divisor  = big_q;
      end
      ST_IDLE, ST_DONE: begin
      end
    endcase
  end

  mfcr_mul #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mcand),
    .mplier_i(mul_mplier),
    .addend_i(mul_addend),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  mfcr_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
      out_q     <= '0;
      wa_q      <= '0;
      na_q      <= '0;
      da_q      <= '0;
      wb_q      <= '0;
      nb_q      <= '0;
      db_q      <= '0;
      big_q     <= '0;
      small_q   <= '0;
      rna_q     <= '0;
      rda_q     <= '0;
      rnb_q     <= '0;
      rdb_q     <= '0;
      xa_q      <= '0;
      gt_q      <= 1'b0;
      zd_q      <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          start_q <= s_accept && (W'(in_item.denom_a) != '0) &&
                     (W'(in_item.denom_b) != '0);
          if (s_accept) begin
            wa_q <= W'(in_item.whole_a);
            na_q <= W'(in_item.numer_a);
            da_q <= W'(in_item.denom_a);
            wb_q <= W'(in_item.whole_b);
            nb_q <= W'(in_item.numer_b);
            db_q <= W'(in_item.denom_b);
            gt_q  <= 1'b0;
            rna_q <= '0;
            rda_q <= '0;
            rnb_q <= '0;
            rdb_q <= '0;
            if (W'(in_item.denom_a) == '0 || W'(in_item.denom_b) == '0) begin
              zd_q    <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              zd_q    <= 1'b0;
              state_q <= ST_MUL_IA;
            end
          end
        end
        ST_MUL_IA: begin
          start_q <= mul_done;
          if (mul_done) begin
            state_q <= ST_MUL_XA;
          end
        end
        ST_MUL_XA: begin
          start_q <= mul_done;
          if (mul_done) begin
            xa_q    <= mul_prod;
            state_q <= ST_MUL_IB;
          end
        end
        ST_MUL_IB: begin
          start_q <= mul_done;
          if (mul_done) begin
            state_q <= ST_MUL_XB;
          end
        end
        ST_MUL_XB: begin
          start_q <= mul_done && (na_q != '0 || nb_q != '0);
          if (mul_done) begin
            gt_q <= (xa_q > mul_prod);
            priority if (na_q != '0) begin
              big_q   <= da_q;
              small_q <= na_q;
              state_q <= ST_GCD_A;
            end else if (nb_q != '0) begin
              rna_q   <= '0;
              rda_q   <= W'(1);
              big_q   <= db_q;
              small_q <= nb_q;
              state_q <= ST_GCD_B;
            end else begin
              rna_q   <= '0;
              rda_q   <= W'(1);
              rnb_q   <= '0;
              rdb_q   <= W'(1);
              state_q <= ST_DONE;
            end
          end
        end
        ST_GCD_A, ST_GCD_B: begin
          start_q <= div_done;
          if (div_done) begin
            // big takes small each step; once the remainder is zero it holds the gcd
            big_q   <= small_q;
            small_q <= div_rem;
            if (div_rem == '0) begin
              state_q <= (state_q == ST_GCD_A) ? ST_DIVN_A : ST_DIVN_B;
            end
          end
        end
        ST_DIVN_A: begin
          start_q <= div_done;
          if (div_done) begin
            rna_q   <= div_quot;
            state_q <= ST_DIVD_A;
          end
        end
        ST_DIVD_A: begin
          start_q <= div_done && (nb_q != '0);
          if (div_done) begin
            rda_q <= div_quot;
            if (nb_q != '0) begin
              big_q   <= db_q;
              small_q <= nb_q;
              state_q <= ST_GCD_B;
            end else begin
              rnb_q   <= '0;
              rdb_q   <= W'(1);
              state_q <= ST_DONE;
            end
          end
        end
        ST_DIVN_B: begin
          start_q <= div_done;
          if (div_done) begin
            rnb_q   <= div_quot;
            state_q <= ST_DIVD_B;
          end
        end
        ST_DIVD_B: begin
          start_q <= 1'b0;
          if (div_done) begin
            rdb_q   <= div_quot;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          start_q <= 1'b0;
          // hold the result until the output register frees up
          if (out_free) begin
            out_q.pad              <= '0;
            out_q.zero_denominator <= zd_q;
            out_q.a_greater        <= gt_q;
            out_q.red_numer_a      <= FIELD_W'(rna_q);
            out_q.red_denom_a      <= FIELD_W'(rda_q);
            out_q.red_numer_b      <= FIELD_W'(rnb_q);
            out_q.red_denom_b      <= FIELD_W'(rdb_q);
            state_q                <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  a_single_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (div_divisor != '0))
    else $error("divider started with a zero divisor");

  a_zero_den_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[OUT_ZD_BIT]) |->
      (m_axis_tdata_o[OUT_ZD_BIT-1:0] == '0))
    else $error("zero denominator result carries nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o)
    else $error("ready stayed high after an item was accepted");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_IA || state_q == ST_MUL_XA ||
                  state_q == ST_MUL_IB || state_q == ST_MUL_XB))
    else $error("multiplier finished outside a product step");

endmodule
